/* rtl/obpf_pkg.sv */
// types, codes and helper functions for the obstacle boundary penalty force block
// no dependencies; imported by obstacle_boundary_penalty_force

package obpf_pkg;

    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 72;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COORD_W     = 10;
    localparam int NUM_PTS     = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_AMP     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OBS_VX  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OBS_VY  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_W  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_H  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_X = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_Y = 3'd6;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    // stencil points: centre, up, down, left, right
    localparam int PT_C = 0;
    localparam int PT_U = 1;
    localparam int PT_D = 2;
    localparam int PT_L = 3;
    localparam int PT_R = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam logic signed [1:0] PT_DX [NUM_PTS] = '{2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1};
    localparam logic signed [1:0] PT_DY [NUM_PTS] = '{2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0};

    typedef enum logic [2:0] {
        MODE_NONE      = 3'd0,
        MODE_X         = 3'd1,
        MODE_Y         = 3'd2,
        MODE_BOTH      = 3'd3,
        MODE_SLASH     = 3'd4,
        MODE_BACKSLASH = 3'd5
    } mode_t;

    typedef struct packed {
        logic [NUM_PTS-1:0] ok;
        logic               cgrid;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } st1_t;

    typedef struct packed {
        mode_t              mode;
        logic               k17;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
    } st2_t;

    typedef struct packed {
        mode_t       mode;
        logic        k17;
        logic        neg_x;
        logic        neg_y;
        logic [32:0] mag_x;
        logic [32:0] mag_y;
    } st3_t;

    typedef struct packed {
        mode_t       mode;
        logic        k17;
        logic        neg_x;
        logic        neg_y;
        logic        big_x;
        logic        big_y;
        logic [63:0] prod_x;
        logic [63:0] prod_y;
    } st4_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
    } out_t;

    function automatic logic in_grid(coord_t x, coord_t y, logic [7:0] w, logic [7:0] h);
        return !x[COORD_W-1] && !y[COORD_W-1]
            && (x < coord_t'({2'b00, w})) && (y < coord_t'({2'b00, h}));
    endfunction

    // floor of the scaled product with sign, saturated to 32 bits
    function automatic logic [31:0] force_sat(logic [63:0] prod, logic big, logic neg,
                                              logic k17, logic [31:0] amp);
        logic [63:0] m;
        logic [47:0] q;
        logic        rem;
        logic [48:0] qn;
        logic [31:0] r;
        m   = big ? {amp, 32'h0000_0000} : prod;
        q   = k17 ? 48'(m >> 17) : m[63:16];
        rem = k17 ? (|m[16:0]) : (|m[15:0]);
        if (!neg) begin
            r = (|q[47:31]) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            qn = {1'b0, q} + 49'(rem);
            if (qn > 49'h0_8000_0000) begin
                r = 32'h8000_0000;
            end else begin
                r = 32'h0000_0000 - qn[31:0];
            end
        end
        return r;
    endfunction

endpackage

/* rtl/obstacle_boundary_penalty_force.sv */
// obstacle boundary penalty force: obstacle bitmap, stencil read, mode and force pipeline
// depends on obpf_pkg
//
// s_ channel takes items: s_tuser is op (write mask bit or process a cell).
// a write item stores its mask bit at once and gives no result; a process item gives
// one result on the m_ channel carrying the mode and the saturated x and y forces.
// one item is taken per clock while s_tready is high; there are five register stages,
// the first loaded at the edge that takes the item, and m_tvalid rises when the item is
// in the last: the bitmap read, flag decode with the velocity differences, magnitude,
// the two 32x32 multiplies and the rounding/saturation stage.
// the bitmap is held in five copies, one read port per stencil point, all written
// together, so the five reads of one item happen in the same cycle.
// after reset the whole bitmap is cleared one cell a cycle, with s_tready low; config
// writes are taken meanwhile. when the receiver stalls, results hold in the output
// register and bubbles inside the pipeline close up, so s_tready stays high until all
// five stages are full. config (cfg_wr_en, cfg_index, cfg_data) is for the user to
// write only while no item is in flight; the block itself does not enforce this.

module obstacle_boundary_penalty_force
    import obpf_pkg::*;
#(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cell_x[6:0], cell_y[13:7], mask_bit[14], vel_x[46:15], vel_y[78:47], zero[79]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // op
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // mode[2:0], force_x[34:3], force_y[66:35], zero[71:67]
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

    logic [31:0]        amp_reg;
    logic signed [31:0] obs_vx_reg;
    logic signed [31:0] obs_vy_reg;
    logic [7:0]         grid_w_reg;
    logic [7:0]         grid_h_reg;
    logic signed [7:0]  shift_x_reg;
    logic signed [7:0]  shift_y_reg;

    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic [4:0] vld_reg;
    logic [4:0] vld_next;
    logic [4:0] en;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    out_t out_reg, out_next;

    logic          rd_reg [NUM_PTS];
    logic [AW-1:0] rd_addr [NUM_PTS];

    logic          s_acc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic [7:0]    eff_w;
    logic [7:0]    eff_h;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_reg     <= 32'h0001_0000;
            obs_vx_reg  <= '0;
            obs_vy_reg  <= '0;
            grid_w_reg  <= 8'd128;
            grid_h_reg  <= 8'd128;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_AMP:     amp_reg     <= cfg_data;
                REG_OBS_VX:  obs_vx_reg  <= cfg_data;
                REG_OBS_VY:  obs_vy_reg  <= cfg_data;
                REG_GRID_W:  grid_w_reg  <= cfg_data[7:0];
                REG_GRID_H:  grid_h_reg  <= cfg_data[7:0];
                REG_SHIFT_X: shift_x_reg <= cfg_data[7:0];
                REG_SHIFT_Y: shift_y_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == LAST_ADDR) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // stage enables, bubbles collapse
    always_comb begin
        en[4] = !vld_reg[4] || m_tready;
        for (int i = 3; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0] && !clearing_reg;
    assign s_acc    = s_tvalid && s_tready;

    assign eff_w = (int'(grid_w_reg) < MAX_WIDTH)  ? grid_w_reg : 8'(MAX_WIDTH);
    assign eff_h = (int'(grid_h_reg) < MAX_HEIGHT) ? grid_h_reg : 8'(MAX_HEIGHT);

    // mask write port
    always_comb begin
        if (clearing_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = 1'b0;
        end else begin
            wr_en   = s_acc && (s_tuser == OP_WRITE)
                   && (int'(s_tdata[6:0]) < MAX_WIDTH) && (int'(s_tdata[13:7]) < MAX_HEIGHT);
            wr_addr = AW'(s_tdata[13:7]) * ROW_STRIDE + AW'(s_tdata[6:0]);
            wr_data = s_tdata[14];
        end
    end

    // stage 1: stencil coordinates and read addresses
    always_comb begin
        coord_t cx, cy, sx, sy, nx, ny, ox, oy;
        cx = coord_t'({3'b000, s_tdata[6:0]});
        cy = coord_t'({3'b000, s_tdata[13:7]});
        sx = coord_t'(shift_x_reg);
        sy = coord_t'(shift_y_reg);
        for (int p = 0; p < NUM_PTS; p++) begin
            nx = cx + coord_t'(PT_DX[p]);
            ny = cy + coord_t'(PT_DY[p]);
            ox = nx - sx;
            oy = ny - sy;
            s1_next.ok[p] = in_grid(nx, ny, eff_w, eff_h) && in_grid(ox, oy, eff_w, eff_h);
            rd_addr[p] = AW'(unsigned'(oy)) * ROW_STRIDE + AW'(unsigned'(ox));
        end
        s1_next.cgrid = in_grid(cx, cy, eff_w, eff_h);
        s1_next.vel_x = s_tdata[46:15];
        s1_next.vel_y = s_tdata[78:47];
    end

    // five bitmap copies, one read port each
    for (genvar g = 0; g < NUM_PTS; g++) begin : g_copy
        logic mask_mem [DEPTH];
        always_ff @(posedge aclk) begin
            if (wr_en) begin
                mask_mem[wr_addr] <= wr_data;
            end
            if (en[0]) begin
                rd_reg[g] <= mask_mem[rd_addr[g]];
            end
        end
    end

    // stage 2: flags, mode and operand selection
    always_comb begin
        logic [NUM_PTS-1:0] fl;
        logic               up, dn, lf, rt, live;
        logic [2:0]         total;
        logic signed [32:0] vx, vy, dx, dy, d_xy, d_yx, sum;
        for (int p = 0; p < NUM_PTS; p++) begin
            fl[p] = s1_reg.ok[p] && rd_reg[p];
        end
        up    = fl[PT_U];
        dn    = fl[PT_D];
        lf    = fl[PT_L];
        rt    = fl[PT_R];
        live  = s1_reg.cgrid && !fl[PT_C];
        total = {2'b00, up} + {2'b00, dn} + {2'b00, lf} + {2'b00, rt};
        vx    = 33'(s1_reg.vel_x);
        vy    = 33'(s1_reg.vel_y);
        dx    = vx - 33'(obs_vx_reg);
        dy    = vy - 33'(obs_vy_reg);
        d_xy  = vx - vy;
        d_yx  = vy - vx;
        sum   = vx + vy;
        if (!live) begin
            s2_next.mode = MODE_NONE;
        end else if (total >= 3'd3) begin
            s2_next.mode = MODE_BOTH;
        end else if ((total == 3'd1 && (up || dn)) || (up && dn)) begin
            s2_next.mode = MODE_Y;
        end else if ((total == 3'd1 && (lf || rt)) || (lf && rt)) begin
            s2_next.mode = MODE_X;
        end else if ((up && rt) || (dn && lf)) begin
            s2_next.mode = MODE_BACKSLASH;
        end else if ((up && lf) || (dn && rt)) begin
            s2_next.mode = MODE_SLASH;
        end else begin
            s2_next.mode = MODE_NONE;
        end
        s2_next.k17 = (s2_next.mode == MODE_SLASH) || (s2_next.mode == MODE_BACKSLASH);
        case (s2_next.mode)
            MODE_BOTH: begin
                s2_next.d_x = dx;
                s2_next.d_y = dy;
            end
            MODE_Y: begin
                s2_next.d_x = '0;
                s2_next.d_y = dy;
            end
            MODE_X: begin
                s2_next.d_x = dx;
                s2_next.d_y = '0;
            end
            MODE_BACKSLASH: begin
                s2_next.d_x = d_xy;
                s2_next.d_y = d_yx;
            end
            MODE_SLASH: begin
                s2_next.d_x = sum;
                s2_next.d_y = sum;
            end
            default: begin
                s2_next.d_x = '0;
                s2_next.d_y = '0;
            end
        endcase
    end

    // stage 3: sign of the force and operand magnitude
    always_comb begin
        s3_next.mode  = s2_reg.mode;
        s3_next.k17   = s2_reg.k17;
        s3_next.neg_x = !s2_reg.d_x[32] && (s2_reg.d_x != '0);
        s3_next.neg_y = !s2_reg.d_y[32] && (s2_reg.d_y != '0);
        s3_next.mag_x = s2_reg.d_x[32] ? 33'(-s2_reg.d_x) : 33'(s2_reg.d_x);
        s3_next.mag_y = s2_reg.d_y[32] ? 33'(-s2_reg.d_y) : 33'(s2_reg.d_y);
    end

    // stage 4: multiplies, a magnitude of exactly 2^32 is carried as a flag
    always_comb begin
        s4_next.mode   = s3_reg.mode;
        s4_next.k17    = s3_reg.k17;
        s4_next.neg_x  = s3_reg.neg_x;
        s4_next.neg_y  = s3_reg.neg_y;
        s4_next.big_x  = s3_reg.mag_x[32];
        s4_next.big_y  = s3_reg.mag_y[32];
        s4_next.prod_x = 64'(s3_reg.mag_x[31:0]) * 64'(amp_reg);
        s4_next.prod_y = 64'(s3_reg.mag_y[31:0]) * 64'(amp_reg);
    end

    // stage 5: scaling, rounding and saturation
    always_comb begin
        out_next.mode    = s4_reg.mode;
        out_next.force_x = force_sat(s4_reg.prod_x, s4_reg.big_x, s4_reg.neg_x,
                                     s4_reg.k17, amp_reg);
        out_next.force_y = force_sat(s4_reg.prod_y, s4_reg.big_y, s4_reg.neg_y,
                                     s4_reg.k17, amp_reg);
    end

    assign vld_next = {vld_reg[3:0], s_acc && (s_tuser == OP_PROCESS)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < 5; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_reg <= s1_next;
        end
        if (en[1]) begin
            s2_reg <= s2_next;
        end
        if (en[2]) begin
            s3_reg <= s3_next;
        end
        if (en[3]) begin
            s4_reg <= s4_next;
        end
        if (en[4]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[4];
    assign m_tdata  = {5'b00000, out_reg.force_y, out_reg.force_x, out_reg.mode};

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// testbench for obstacle_boundary_penalty_force: mirrors the obstacle bitmap and the
// registers, predicts mode and saturated forces for every process item and checks them
// depends on obpf_pkg and the obstacle_boundary_penalty_force rtl only

module tb
    import obpf_pkg::*;
();

    localparam int MAX_W = 128;
    localparam int MAX_H = 128;
    // covers the bitmap clear after reset plus generous margin
    localparam int WATCHDOG_LIMIT = 70000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    obstacle_boundary_penalty_force uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    // mirrored block state
    bit                 mask_mirror [MAX_W*MAX_H];
    logic [31:0]        amp_q = 32'h0001_0000;
    logic signed [31:0] obs_vx = '0;
    logic signed [31:0] obs_vy = '0;
    logic [7:0]         grid_w = 8'd128;
    logic [7:0]         grid_h = 8'd128;
    logic signed [7:0]  shift_x_r = '0;
    logic signed [7:0]  shift_y_r = '0;

    out_t pending_forces [$];
    int   errors = 0;
    int   items_sent = 0;
    int   results_checked = 0;
    int   config_phases = 0;
    int   mode_count [8];
    bit   src_idle = 1'b1;
    bit   snk_idle = 1'b1;

    function automatic int eff_w();
        return (grid_w < 8'd128) ? int'(grid_w) : MAX_W;
    endfunction

    function automatic int eff_h();
        return (grid_h < 8'd128) ? int'(grid_h) : MAX_H;
    endfunction

    function automatic bit on_grid(int x, int y);
        return x >= 0 && x < eff_w() && y >= 0 && y < eff_h();
    endfunction

    function automatic bit solid_cell(int x, int y);
        int ox;
        int oy;
        ox = x - int'(shift_x_r);
        oy = y - int'(shift_y_r);
        if (!on_grid(x, y) || !on_grid(ox, oy)) return 1'b0;
        return mask_mirror[ox + oy*MAX_W];
    endfunction

    // floor(-amp*d / 2^k), saturated to 32 bits
    function automatic logic [31:0] penalty_force(logic signed [33:0] d, int k);
        logic [33:0] absd;
        logic [95:0] mag;
        logic [95:0] q;
        absd = (d < 0) ? -d : d;
        mag  = {62'b0, absd} * {64'b0, amp_q};
        q    = mag >> k;
        if (!(d > 0)) return (q > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        if ((mag & ((96'd1 << k) - 96'd1)) != 0) q = q + 96'd1;
        if (q > 96'h8000_0000) q = 96'h8000_0000;
        return 32'h0 - q[31:0];
    endfunction

    function automatic out_t predict_cell_force(int x, int y, logic [31:0] vx, logic [31:0] vy);
        out_t              r;
        bit                up, dn, lf, rt;
        int                total;
        logic signed [33:0] evx, evy, eox, eoy;
        r.mode    = MODE_NONE;
        r.force_x = '0;
        r.force_y = '0;
        if (on_grid(x, y) && !solid_cell(x, y)) begin
            up    = solid_cell(x, y - 1);
            dn    = solid_cell(x, y + 1);
            lf    = solid_cell(x - 1, y);
            rt    = solid_cell(x + 1, y);
            total = int'(up) + int'(dn) + int'(lf) + int'(rt);
            evx   = $signed(vx);
            evy   = $signed(vy);
            eox   = obs_vx;
            eoy   = obs_vy;
            if (total >= 3) begin
                r.mode    = MODE_BOTH;
                r.force_x = penalty_force(evx - eox, 16);
                r.force_y = penalty_force(evy - eoy, 16);
            end else if ((total == 1 && (up || dn)) || (up && dn)) begin
                r.mode    = MODE_Y;
                r.force_y = penalty_force(evy - eoy, 16);
            end else if ((total == 1 && (lf || rt)) || (lf && rt)) begin
                r.mode    = MODE_X;
                r.force_x = penalty_force(evx - eox, 16);
            end else if ((up && rt) || (dn && lf)) begin
                r.mode    = MODE_BACKSLASH;
                r.force_x = penalty_force(evx - evy, 17);
                r.force_y = penalty_force(evy - evx, 17);
            end else if ((up && lf) || (dn && rt)) begin
                r.mode    = MODE_SLASH;
                r.force_x = penalty_force(evx + evy, 17);
                r.force_y = r.force_x;
            end
        end
        return r;
    endfunction

    task automatic send_item(logic op, int x, int y, bit mb, logic [31:0] vx, logic [31:0] vy);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, vy, vx, mb, 7'(y), 7'(x)};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_WRITE) begin
            mask_mirror[(x & 127) + (y & 127)*MAX_W] = mb;
        end else begin
            pending_forces = {pending_forces, predict_cell_force(x & 127, y & 127, vx, vy)};
        end
        items_sent++;
    endtask

    // pause the source until every outstanding result is back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_forces.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_AMP:     amp_q     = val;
            REG_OBS_VX:  obs_vx    = val;
            REG_OBS_VY:  obs_vy    = val;
            REG_GRID_W:  grid_w    = val[7:0];
            REG_GRID_H:  grid_h    = val[7:0];
            REG_SHIFT_X: shift_x_r = val[7:0];
            REG_SHIFT_Y: shift_y_r = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [31:0] amp, logic [31:0] ovx, logic [31:0] ovy,
                                logic [7:0] gw, logic [7:0] gh, logic [7:0] sx, logic [7:0] sy);
        wait_results_drained();
        cfg_write(REG_AMP, amp);
        cfg_write(REG_OBS_VX, ovx);
        cfg_write(REG_OBS_VY, ovy);
        cfg_write(REG_GRID_W, {24'($urandom), gw});
        cfg_write(REG_GRID_H, {24'($urandom), gh});
        cfg_write(REG_SHIFT_X, {24'($urandom), sx});
        cfg_write(REG_SHIFT_Y, {24'($urandom), sy});
        config_phases++;
    endtask

    // pattern bits follow the stencil points: centre, up, down, left, right
    task automatic set_stencil(int cx, int cy, bit [4:0] pat, bit rewrites);
        int ox;
        int oy;
        for (int i = 0; i < NUM_PTS; i++) begin
            ox = cx + int'(PT_DX[i]) - int'(shift_x_r);
            oy = cy + int'(PT_DY[i]) - int'(shift_y_r);
            if (ox >= 0 && ox < MAX_W && oy >= 0 && oy < MAX_H
                    && (mask_mirror[ox + oy*MAX_W] != pat[i]
                        || (rewrites && $urandom_range(0, 3) == 0))) begin
                send_item(OP_WRITE, ox, oy, pat[i], $urandom, $urandom);
            end
        end
    endtask

    function automatic logic [31:0] rand_vel(logic [31:0] near);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0: return r;
            1: return {{14{r[17]}}, r[17:0]};
            2: begin
                case (r[1:0])
                    2'd0: return 32'h7FFF_FFFF;
                    2'd1: return 32'h8000_0000;
                    2'd2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return near + {{20{r[11]}}, r[11:0]};
        endcase
    endfunction

    // centre coordinate whose stored position lies inside the bitmap where possible
    function automatic int pick_coord(int shift, int extent);
        int lo;
        int hi;
        lo = (shift > 0) ? shift : 0;
        hi = (127 + shift < extent - 1) ? 127 + shift : extent - 1;
        if (hi < lo || $urandom_range(0, 7) == 0) return $urandom_range(0, 127);
        return $urandom_range(lo, hi);
    endfunction

    task automatic random_step();
        int  cx;
        int  cy;
        bit [4:0] pat;
        case ($urandom_range(0, 7))
            0: send_item(OP_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 1), $urandom, $urandom);
            1: send_item(OP_PROCESS, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 1), rand_vel(obs_vx), rand_vel(obs_vy));
            default: begin
                cx     = pick_coord(int'(shift_x_r), eff_w());
                cy     = pick_coord(int'(shift_y_r), eff_h());
                pat    = 5'($urandom);
                pat[0] = ($urandom_range(0, 7) == 0);
                set_stencil(cx, cy, pat, 1'b1);
                send_item(OP_PROCESS, cx, cy, $urandom_range(0, 1),
                          rand_vel(obs_vx), rand_vel(obs_vy));
            end
        endcase
    endtask

    // walk the neighbour patterns one bit at a time, but for the step to 5'b11110, at reset settings
    task automatic test_stencil_modes();
        bit [4:0]    walk [15] = '{5'b00000, 5'b00010, 5'b10010, 5'b10000, 5'b11000,
                                   5'b11100, 5'b10100, 5'b00100, 5'b00110, 5'b01110,
                                   5'b01010, 5'b01000, 5'b01100, 5'b11110, 5'b11111};
        logic [31:0] vels [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                  32'hFFFF_FFFF, 32'h0001_0000};
        src_idle = 1'b0;
        snk_idle = 1'b0;
        for (int i = 0; i < 15; i++) begin
            set_stencil(10, 10, walk[i], 1'b0);
            send_item(OP_PROCESS, 10, 10, i[0], vels[i % 5], vels[(i + 2) % 5]);
        end
        set_stencil(10, 10, 5'b00000, 1'b0);
    endtask

    task automatic test_config_extremes();
        logic [31:0] amps [6] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000,
                                  32'hFFFF_FFFF, 32'h0002_0000, 32'h0003_8000};
        logic [31:0] ovxs [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h1, 32'h0};
        logic [31:0] ovys [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                  32'hFFFF_FFFF, 32'h0};
        logic [7:0]  gws [6]  = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd16, 8'd128};
        logic [7:0]  ghs [6]  = '{8'd128, 8'd1, 8'd128, 8'd200, 8'd9, 8'd1};
        logic [7:0]  sxs [6]  = '{8'h00, 8'h00, 8'h05, 8'h7F, 8'h80, 8'hFF};
        logic [7:0]  sys [6]  = '{8'h00, 8'h00, 8'hFD, 8'h80, 8'h7F, 8'h01};
        for (int i = 0; i < 6; i++) begin
            apply_config(amps[i], ovxs[i], ovys[i], gws[i], ghs[i], sxs[i], sys[i]);
            src_idle = i[0];
            snk_idle = i[1] | i[0];
            repeat (12) random_step();
        end
    endtask

    task automatic test_random_mix();
        logic [31:0] amp;
        logic [7:0]  gw;
        logic [7:0]  gh;
        logic [7:0]  sx;
        logic [7:0]  sy;
        while (items_sent < 450) begin
            case ($urandom_range(0, 3))
                0: amp = $urandom;
                1: amp = 32'h0001_0000;
                2: amp = $urandom_range(0, 32'h0004_0000);
                default: amp = $urandom >> 8;
            endcase
            gw = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 128));
            gh = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 128));
            sx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8) - 4);
            sy = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8) - 4);
            apply_config(amp, rand_vel(32'h0), rand_vel(32'h0), gw, gh, sx, sy);
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            repeat (15) random_step();
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    // result checking and receiver stalls
    always @(posedge aclk) begin : result_check
        out_t       want;
        logic [2:0] got_mode;
        int         stall;
        if (aresetn && m_tvalid && m_tready) begin
            got_mode = m_tdata[2:0];
            if (pending_forces.size() == 0) begin
                report_mismatch("unexpected result, mode", 32'h0, 32'(got_mode));
            end else begin
                want = pending_forces.pop_front();
                if (got_mode != want.mode)
                    report_mismatch("mode", 32'(want.mode), 32'(got_mode));
                if (m_tdata[34:3] != want.force_x)
                    report_mismatch("force_x", want.force_x, m_tdata[34:3]);
                if (m_tdata[66:35] != want.force_y)
                    report_mismatch("force_y", want.force_y, m_tdata[66:35]);
                mode_count[got_mode]++;
                results_checked++;
            end
            stall = snk_idle ? $urandom_range(0, 10) : 0;
        end
        if (stall > 0) begin
            m_tready <= 1'b0;
            stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watchdog
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles with no item moving", quiet);
            $display("obstacle_boundary_penalty_force verification failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_stencil_modes();
        test_config_extremes();
        test_random_mix();
        wait_results_drained();
        $display("sent %0d items over %0d register settings, checked %0d results",
                 items_sent, config_phases, results_checked);
        $display("modes seen: none %0d, x %0d, y %0d, both %0d, slash %0d, backslash %0d",
                 mode_count[0], mode_count[1], mode_count[2], mode_count[3],
                 mode_count[4], mode_count[5]);
        if (errors == 0) begin
            $display("obstacle_boundary_penalty_force verification clean");
        end else begin
            $display("obstacle_boundary_penalty_force verification failed");
        end
        $finish;
    end

endmodule
